@@ hw/rtl/cpf_pkg.sv @@
// Shared types, codes and constants of the common packet format item parser.
// No dependencies; every other file of the block imports this package.
package cpf_pkg;

  localparam int unsigned INFO_ITEMS_DEF = 2;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned OUT_TDATA_W    = 200;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_O2T = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_T2O = 8'd1;

  localparam logic [15:0] O2T_TYPE_RESET = 16'h8000;
  localparam logic [15:0] T2O_TYPE_RESET = 16'h8001;

  typedef enum logic [14:0] {
    PH_COUNT     = 15'h0001,
    PH_ADDR_TYPE = 15'h0002,
    PH_ADDR_LEN  = 15'h0004,
    PH_CONN      = 15'h0008,
    PH_SEQ       = 15'h0010,
    PH_DATA_TYPE = 15'h0020,
    PH_DATA_LEN  = 15'h0040,
    PH_SKIP      = 15'h0080,
    PH_INFO_TYPE = 15'h0100,
    PH_INFO_LEN  = 15'h0200,
    PH_INFO_FAM  = 15'h0400,
    PH_INFO_PORT = 15'h0800,
    PH_INFO_ADDR = 15'h1000,
    PH_INFO_ZERO = 15'h2000,
    PH_DONE      = 15'h4000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ADDR = 2'd0,
    KIND_DATA = 2'd1,
    KIND_INFO = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] type_id;
    logic [15:0] length;
    logic [15:0] family;
    logic [15:0] port;
    logic [31:0] addr;
  } info_t;

  // Per-frame summary handed from the parser to the emitter on the final byte
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] items_total;
    logic        has_data;
    logic [15:0] addr_type;
    logic [15:0] addr_len;
    logic [31:0] conn_id;
    logic [31:0] seq_num;
    logic [15:0] data_type;
    logic [15:0] data_len;
    logic [15:0] data_offset;
  } frame_sum_t;

  // Result word layout, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] socket_addr;
    logic [15:0] socket_port;
    logic [15:0] socket_family;
    logic [15:0] payload_offset;
    logic [31:0] seq_value;
    logic [31:0] connection_id;
    logic [15:0] item_length;
    logic [15:0] type_id;
    logic [15:0] items_total;
    logic [1:0]  status;
  } out_rec_t;

  // Index of the last byte of the field read in a phase
  function automatic logic [2:0] field_last(input phase_e ph);
    logic [2:0] n;
    unique case (ph) inside
      PH_COUNT, PH_ADDR_TYPE, PH_ADDR_LEN, PH_DATA_TYPE, PH_DATA_LEN,
      PH_INFO_TYPE, PH_INFO_LEN, PH_INFO_FAM, PH_INFO_PORT: n = 3'd1;
      PH_CONN, PH_SEQ, PH_INFO_ADDR:                        n = 3'd3;
      PH_INFO_ZERO:                                         n = 3'd7;
      default:                                              n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/cpf_item_parser_core.sv @@
// Top level of the common packet format item parser: configuration registers,
// stream handshake and the parser and emitter. Depends on cpf_pkg.
//
// Frame bytes enter on the s_axis channel, one byte per word, tlast on the
// final byte. The parser reads the item count, the address item, the data item
// and up to INFO_ITEMS socket address info items, one byte per cycle. On the
// final byte the frame summary moves into the result register, and the records
// of that frame leave on m_axis, one word per cycle when not stalled: address
// record, data record when the count is two or more, then the completed info
// items; tlast marks the last record, tuser carries the record kind.
// Throughput is one byte per cycle; the first record shows the cycle after the
// final byte is taken. A final byte waits only while the previous frame still
// has records queued past the current cycle, since the result register holds
// one frame; other bytes are never held back, whatever m_axis does.
// Reset returns the parser to the item count and empties the result register;
// the info type registers return to 0x8000 and 0x8001. The cfg channel is
// always ready; indexes other than 0 and 1 are ignored.
module cpf_item_parser_core #(
  parameter int unsigned INFO_ITEMS = cpf_pkg::INFO_ITEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
  input  logic                               s_axis_tlast,  // frame_end
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [17:2] items_total, [33:18] type_id, [49:34] item_length,
  // [81:50] connection_id, [113:82] seq_value, [129:114] payload_offset,
  // [145:130] socket_family, [161:146] socket_port, [193:162] socket_addr,
  // [199:194] zero
  output logic [cpf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [1:0]                         m_axis_tuser,  // [1:0] record_kind
  output logic                               m_axis_tlast,  // last_record
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cpf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cpf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cpf_pkg::*;

  logic [15:0]            o2t_type_q, t2o_type_q;
  logic                   in_accept;
  logic                   can_load;
  frame_sum_t             sum;
  info_t [INFO_ITEMS-1:0] info;
  logic [$clog2(INFO_ITEMS+1)-1:0] info_n;
  out_rec_t               rec;
  kind_e                  kind;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o2t_type_q <= O2T_TYPE_RESET;
      t2o_type_q <= T2O_TYPE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_O2T: o2t_type_q <= cfg_data_i;
        CFG_IDX_T2O: t2o_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold a final byte only while the result register stays occupied
  assign s_axis_tready = !s_axis_tlast || can_load;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  cpf_parser #(
    .INFO_ITEMS (INFO_ITEMS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .data_byte_i (s_axis_tdata),
    .frame_end_i (s_axis_tlast),
    .cfg_o2t_i   (o2t_type_q),
    .cfg_t2o_i   (t2o_type_q),
    .sum_o       (sum),
    .info_o      (info),
    .info_n_o    (info_n)
  );

  cpf_emitter #(
    .INFO_ITEMS (INFO_ITEMS)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept && s_axis_tlast),
    .sum_i      (sum),
    .info_i     (info),
    .info_n_i   (info_n),
    .m_tready_i (m_axis_tready),
    .can_load_o (can_load),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (rec),
    .m_tuser_o  (kind),
    .m_tlast_o  (m_axis_tlast)
  );

  assign m_axis_tdata = rec;
  assign m_axis_tuser = kind;

endmodule

@@ hw/rtl/cpf_parser.sv @@
// Per-byte frame parser: field assembly, phase sequencing and frame summary.
// Depends on cpf_pkg.
module cpf_parser #(
  parameter int unsigned INFO_ITEMS = cpf_pkg::INFO_ITEMS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_accept_i,
  input  logic [7:0]                            data_byte_i,
  input  logic                                  frame_end_i,
  input  logic [15:0]                           cfg_o2t_i,
  input  logic [15:0]                           cfg_t2o_i,
  output cpf_pkg::frame_sum_t                   sum_o,
  output cpf_pkg::info_t [INFO_ITEMS-1:0]       info_o,
  output logic [$clog2(INFO_ITEMS+1)-1:0]       info_n_o
);
  import cpf_pkg::*;

  localparam int unsigned IdxW = $clog2(INFO_ITEMS + 1);

  phase_e                 phase_q, phase_d;
  logic [15:0]            byte_cnt_q, byte_cnt_d;
  logic [31:0]            shift_q, shift_d;
  logic [2:0]             fidx_q, fidx_d;
  logic [15:0]            skip_q, skip_d;
  logic [15:0]            count_q, count_d;
  logic [15:0]            addr_type_q, addr_type_d, addr_len_q, addr_len_d;
  logic [31:0]            conn_q, conn_d, seq_q, seq_d;
  logic [15:0]            data_type_q, data_type_d, data_len_q, data_len_d;
  logic [15:0]            data_off_q, data_off_d;
  info_t [INFO_ITEMS-1:0] info_q, info_d;
  logic [IdxW-1:0]        info_idx_q, info_idx_d;
  logic                   trail_q, trail_d;

  logic [31:0] acc;
  logic [15:0] word;
  logic        wr_type, wr_len, wr_fam, wr_port, wr_addr;

  function automatic phase_e start_info(input logic [15:0] cnt, input logic [IdxW-1:0] idx);
    logic more;
    more = ({1'b0, cnt} > (17'(idx) + 17'd2)) && (idx < IdxW'(INFO_ITEMS));
    return more ? PH_INFO_TYPE : PH_DONE;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q + 16'd1;
    shift_d     = shift_q;
    fidx_d      = fidx_q;
    skip_d      = skip_q;
    count_d     = count_q;
    addr_type_d = addr_type_q;
    addr_len_d  = addr_len_q;
    conn_d      = conn_q;
    seq_d       = seq_q;
    data_type_d = data_type_q;
    data_len_d  = data_len_q;
    data_off_d  = data_off_q;
    info_d      = info_q;
    info_idx_d  = info_idx_q;
    trail_d     = trail_q;
    wr_type     = 1'b0;
    wr_len      = 1'b0;
    wr_fam      = 1'b0;
    wr_port     = 1'b0;
    wr_addr     = 1'b0;

    // only the first four bytes of a field land in the shifter
    acc  = shift_q | (fidx_q[2] ? 32'd0
                                : ({24'd0, data_byte_i} << {fidx_q[1:0], 3'b000}));
    word = acc[15:0];

    if (phase_q == PH_DONE) begin
      trail_d = 1'b1;
    end else if (phase_q == PH_SKIP) begin
      skip_d = skip_q - 16'd1;
      if (skip_q == 16'd1) begin
        phase_d = start_info(count_q, info_idx_q);
      end
    end else if (fidx_q == field_last(phase_q)) begin
      shift_d = 32'd0;
      fidx_d  = 3'd0;
      unique case (phase_q)
        PH_COUNT: begin
          count_d = word;
          phase_d = (word != 16'd0) ? PH_ADDR_TYPE : PH_DONE;
        end
        PH_ADDR_TYPE: begin
          addr_type_d = word;
          phase_d     = PH_ADDR_LEN;
        end
        PH_ADDR_LEN: begin
          addr_len_d = word;
          if (word >= 16'd4) begin
            phase_d = PH_CONN;
          end else begin
            phase_d = (count_q >= 16'd2) ? PH_DATA_TYPE : PH_DONE;
          end
        end
        PH_CONN: begin
          conn_d = acc;
          if (addr_len_q == 16'd8) begin
            phase_d = PH_SEQ;
          end else begin
            phase_d = (count_q >= 16'd2) ? PH_DATA_TYPE : PH_DONE;
          end
        end
        PH_SEQ: begin
          seq_d   = acc;
          phase_d = (count_q >= 16'd2) ? PH_DATA_TYPE : PH_DONE;
        end
        PH_DATA_TYPE: begin
          data_type_d = word;
          phase_d     = PH_DATA_LEN;
        end
        PH_DATA_LEN: begin
          data_len_d = word;
          data_off_d = byte_cnt_q + 16'd1;
          if (word != 16'd0) begin
            skip_d  = word;
            phase_d = PH_SKIP;
          end else begin
            phase_d = start_info(count_q, info_idx_q);
          end
        end
        PH_INFO_TYPE: begin
          if (word == cfg_o2t_i || word == cfg_t2o_i) begin
            wr_type = 1'b1;
            phase_d = PH_INFO_LEN;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_INFO_LEN: begin
          wr_len  = 1'b1;
          phase_d = PH_INFO_FAM;
        end
        PH_INFO_FAM: begin
          wr_fam  = 1'b1;
          phase_d = PH_INFO_PORT;
        end
        PH_INFO_PORT: begin
          wr_port = 1'b1;
          phase_d = PH_INFO_ADDR;
        end
        PH_INFO_ADDR: begin
          wr_addr = 1'b1;
          phase_d = PH_INFO_ZERO;
        end
        PH_INFO_ZERO: begin
          info_idx_d = info_idx_q + IdxW'(1);
          phase_d    = start_info(count_q, info_idx_q + IdxW'(1));
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end else begin
      shift_d = acc;
      fidx_d  = fidx_q + 3'd1;
    end

    for (int j = 0; j < INFO_ITEMS; j++) begin
      if (info_idx_q == IdxW'(j)) begin
        if (wr_type) info_d[j].type_id = word;
        if (wr_len)  info_d[j].length  = word;
        if (wr_fam)  info_d[j].family  = word;
        if (wr_port) info_d[j].port    = word;
        if (wr_addr) info_d[j].addr    = acc;
      end
    end
  end

  // Summary as it stands after the current byte
  always_comb begin
    if (phase_d != PH_DONE) begin
      sum_o.status = ST_TRUNC;
    end else if (trail_d && count_d <= 16'd2) begin
      sum_o.status = ST_MISMATCH;
    end else begin
      sum_o.status = ST_OK;
    end
    sum_o.items_total = count_d;
    sum_o.has_data    = (count_d >= 16'd2);
    sum_o.addr_type   = addr_type_d;
    sum_o.addr_len    = addr_len_d;
    sum_o.conn_id     = conn_d;
    sum_o.seq_num     = seq_d;
    sum_o.data_type   = data_type_d;
    sum_o.data_len    = data_len_d;
    sum_o.data_offset = data_off_d;
  end

  assign info_o   = info_d;
  assign info_n_o = info_idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COUNT;
      byte_cnt_q  <= '0;
      shift_q     <= '0;
      fidx_q      <= '0;
      skip_q      <= '0;
      count_q     <= '0;
      addr_type_q <= '0;
      addr_len_q  <= '0;
      conn_q      <= '0;
      seq_q       <= '0;
      data_type_q <= '0;
      data_len_q  <= '0;
      data_off_q  <= '0;
      info_q      <= '0;
      info_idx_q  <= '0;
      trail_q     <= 1'b0;
    end else if (in_accept_i) begin
      if (frame_end_i) begin
        // drop all per-frame state once the summary is taken
        phase_q     <= PH_COUNT;
        byte_cnt_q  <= '0;
        shift_q     <= '0;
        fidx_q      <= '0;
        skip_q      <= '0;
        count_q     <= '0;
        addr_type_q <= '0;
        addr_len_q  <= '0;
        conn_q      <= '0;
        seq_q       <= '0;
        data_type_q <= '0;
        data_len_q  <= '0;
        data_off_q  <= '0;
        info_q      <= '0;
        info_idx_q  <= '0;
        trail_q     <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        byte_cnt_q  <= byte_cnt_d;
        shift_q     <= shift_d;
        fidx_q      <= fidx_d;
        skip_q      <= skip_d;
        count_q     <= count_d;
        addr_type_q <= addr_type_d;
        addr_len_q  <= addr_len_d;
        conn_q      <= conn_d;
        seq_q       <= seq_d;
        data_type_q <= data_type_d;
        data_len_q  <= data_len_d;
        data_off_q  <= data_off_d;
        info_q      <= info_d;
        info_idx_q  <= info_idx_d;
        trail_q     <= trail_d;
      end
    end
  end

endmodule

@@ hw/rtl/cpf_emitter.sv @@
// Result register and record sequencer: holds one frame summary and sends
// its records one word per cycle while m_tready_i is high. Depends on cpf_pkg.
module cpf_emitter #(
  parameter int unsigned INFO_ITEMS = cpf_pkg::INFO_ITEMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  cpf_pkg::frame_sum_t             sum_i,
  input  cpf_pkg::info_t [INFO_ITEMS-1:0] info_i,
  input  logic [$clog2(INFO_ITEMS+1)-1:0] info_n_i,
  input  logic                            m_tready_i,
  output logic                            can_load_o,
  output logic                            m_tvalid_o,
  output cpf_pkg::out_rec_t               m_tdata_o,
  output cpf_pkg::kind_e                  m_tuser_o,
  output logic                            m_tlast_o
);
  import cpf_pkg::*;

  localparam int unsigned RecW = $clog2(INFO_ITEMS + 2);

  frame_sum_t             sum_q;
  info_t [INFO_ITEMS-1:0] info_q;
  logic                   busy_q;
  logic [RecW-1:0]        idx_q;
  logic [RecW-1:0]        last_q;
  logic                   is_last;

  assign is_last    = (idx_q == last_q);
  assign can_load_o = !busy_q || (m_tready_i && is_last);
  assign m_tvalid_o = busy_q;
  assign m_tlast_o  = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      last_q <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      last_q <= RecW'(sum_i.has_data) + RecW'(info_n_i);
    end else if (busy_q && m_tready_i) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + RecW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q  <= sum_i;
      info_q <= info_i;
    end
  end

  // Address record first, then data, then the info items in order
  always_comb begin
    m_tdata_o             = '0;
    m_tdata_o.status      = sum_q.status;
    m_tdata_o.items_total = sum_q.items_total;
    m_tuser_o             = KIND_ADDR;
    if (idx_q == '0) begin
      m_tdata_o.type_id       = sum_q.addr_type;
      m_tdata_o.item_length   = sum_q.addr_len;
      m_tdata_o.connection_id = sum_q.conn_id;
      m_tdata_o.seq_value     = sum_q.seq_num;
    end else if (idx_q == RecW'(1)) begin
      m_tuser_o                = KIND_DATA;
      m_tdata_o.type_id        = sum_q.data_type;
      m_tdata_o.item_length    = sum_q.data_len;
      m_tdata_o.payload_offset = sum_q.data_offset;
    end else begin
      m_tuser_o = KIND_INFO;
      for (int j = 0; j < INFO_ITEMS; j++) begin
        if (idx_q == RecW'(j + 2)) begin
          m_tdata_o.type_id       = info_q[j].type_id;
          m_tdata_o.item_length   = info_q[j].length;
          m_tdata_o.socket_family = info_q[j].family;
          m_tdata_o.socket_port   = info_q[j].port;
          m_tdata_o.socket_addr   = info_q[j].addr;
        end
      end
    end
  end

endmodule

@@ hw/rtl/cpf_checker.sv @@
// Port-level checks of the common packet format item parser, bound to the
// top level. Depends on cpf_pkg.
module cpf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cpf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);
  import cpf_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // bytes other than the final one are never held back
  a_byte_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tlast |-> s_axis_tready)
    else $error("non-final byte stalled");

  // a frame's records open with the address record
  a_frame_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast
    |=> !m_axis_tvalid || m_axis_tuser == KIND_ADDR)
    else $error("frame does not open with an address record");

  // an address record that is not last is followed at once by the data record
  a_data_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast && m_axis_tuser == KIND_ADDR
    |=> m_axis_tvalid && m_axis_tuser == KIND_DATA)
    else $error("data record missing after address record");

  // status is shared by every record of a frame
  a_status_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
    |=> m_axis_tvalid && m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]))
    else $error("status differs within a frame");

endmodule

bind cpf_item_parser_core cpf_checker u_cpf_checker (.*);

@@ dv/cpf_item_parser_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the common packet format item parser: streams frame bytes,
// predicts the records of each frame and checks every record word as it leaves.
// Depends on cpf_pkg and cpf_item_parser_core.
module cpf_item_parser_core_tb;
  import cpf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [7:0]  data;
    logic        eof;
    int unsigned gap;
  } frame_word_t;

  typedef struct {
    kind_e    kind;
    out_rec_t fields;
    logic     last;
  } record_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  cpf_item_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial forever #2 clk_i = ~clk_i;

  // Parser state as predicted
  logic [15:0] o2t_type = O2T_TYPE_RESET;
  logic [15:0] t2o_type = T2O_TYPE_RESET;
  phase_e      ph;
  logic [15:0] byte_pos;
  logic [31:0] word_acc;
  int unsigned word_idx;
  logic [15:0] skip_left;
  logic [15:0] count_word;
  logic [15:0] addr_type, addr_len, data_type, data_len, data_offset;
  logic [31:0] conn_id, seq_num;
  info_t       infos [INFO_ITEMS_DEF];
  int unsigned infos_done;
  logic        past_end;

  record_t     expected_records[$];
  frame_word_t frame_words[$];
  logic [7:0]  frame_buf[$];
  frame_word_t next_word;
  logic        have_next    = 1'b0;
  logic        s_taken      = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned stuck_cycles = 0;
  int unsigned sent_bytes   = 0;
  int unsigned n_frames     = 0;
  int unsigned n_errors     = 0;

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int unsigned word_bytes(phase_e p);
    case (p)
      PH_CONN, PH_SEQ, PH_INFO_ADDR: return 4;
      PH_INFO_ZERO:                  return 8;
      PH_SKIP, PH_DONE:              return 1;
      default:                       return 2;
    endcase
  endfunction

  function automatic phase_e next_info();
    if (count_word > 16'd2 && infos_done < 32'(count_word) - 2 && infos_done < INFO_ITEMS_DEF)
      return PH_INFO_TYPE;
    return PH_DONE;
  endfunction

  function automatic phase_e after_address();
    if (count_word >= 16'd2) return PH_DATA_TYPE;
    return PH_DONE;
  endfunction

  task automatic clear_frame_state();
    ph = PH_COUNT;
    byte_pos = '0;
    word_acc = '0;
    word_idx = 0;
    skip_left = '0;
    count_word = '0;
    addr_type = '0;
    addr_len = '0;
    conn_id = '0;
    seq_num = '0;
    data_type = '0;
    data_len = '0;
    data_offset = '0;
    foreach (infos[i]) infos[i] = '0;
    infos_done = 0;
    past_end = 1'b0;
  endtask

  task automatic close_word(input logic [31:0] v);
    logic [15:0] w;
    int unsigned k;
    w = v[15:0];
    k = (infos_done < INFO_ITEMS_DEF) ? infos_done : 0;
    case (ph)
      PH_COUNT: begin
        count_word = w;
        ph = (w >= 16'd1) ? PH_ADDR_TYPE : PH_DONE;
      end
      PH_ADDR_TYPE: begin
        addr_type = w;
        ph = PH_ADDR_LEN;
      end
      PH_ADDR_LEN: begin
        addr_len = w;
        ph = (w >= 16'd4) ? PH_CONN : after_address();
      end
      PH_CONN: begin
        conn_id = v;
        ph = (addr_len == 16'd8) ? PH_SEQ : after_address();
      end
      PH_SEQ: begin
        seq_num = v;
        ph = after_address();
      end
      PH_DATA_TYPE: begin
        data_type = w;
        ph = PH_DATA_LEN;
      end
      PH_DATA_LEN: begin
        data_len = w;
        data_offset = byte_pos + 16'd1;
        if (w != 16'd0) begin
          skip_left = w;
          ph = PH_SKIP;
        end else begin
          ph = next_info();
        end
      end
      PH_INFO_TYPE: begin
        // stop at the first info item of a type neither register names
        if (w == o2t_type || w == t2o_type) begin
          infos[k].type_id = w;
          ph = PH_INFO_LEN;
        end else begin
          ph = PH_DONE;
        end
      end
      PH_INFO_LEN: begin
        infos[k].length = w;
        ph = PH_INFO_FAM;
      end
      PH_INFO_FAM: begin
        infos[k].family = w;
        ph = PH_INFO_PORT;
      end
      PH_INFO_PORT: begin
        infos[k].port = w;
        ph = PH_INFO_ADDR;
      end
      PH_INFO_ADDR: begin
        infos[k].addr = v;
        ph = PH_INFO_ZERO;
      end
      PH_INFO_ZERO: begin
        infos_done++;
        ph = next_info();
      end
      default: ph = PH_DONE;
    endcase
  endtask

  function automatic record_t new_record(kind_e kind, status_e st);
    record_t r;
    r.kind = kind;
    r.last = 1'b0;
    r.fields = '0;
    r.fields.status = st;
    r.fields.items_total = count_word;
    return r;
  endfunction

  task automatic emit_records();
    record_t recs[$];
    record_t r;
    status_e st;
    if (ph != PH_DONE) st = ST_TRUNC;
    else if (past_end && count_word <= 16'd2) st = ST_MISMATCH;
    else st = ST_OK;
    r = new_record(KIND_ADDR, st);
    r.fields.type_id = addr_type;
    r.fields.item_length = addr_len;
    r.fields.connection_id = conn_id;
    r.fields.seq_value = seq_num;
    recs.push_back(r);
    if (count_word >= 16'd2) begin
      r = new_record(KIND_DATA, st);
      r.fields.type_id = data_type;
      r.fields.item_length = data_len;
      r.fields.payload_offset = data_offset;
      recs.push_back(r);
    end
    for (int unsigned j = 0; j < infos_done && j < INFO_ITEMS_DEF; j++) begin
      r = new_record(KIND_INFO, st);
      r.fields.type_id = infos[j].type_id;
      r.fields.item_length = infos[j].length;
      r.fields.socket_family = infos[j].family;
      r.fields.socket_port = infos[j].port;
      r.fields.socket_addr = infos[j].addr;
      recs.push_back(r);
    end
    recs[recs.size()-1].last = 1'b1;
    foreach (recs[i]) expected_records.push_back(recs[i]);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    logic [31:0] v;
    if (ph == PH_DONE) begin
      past_end = 1'b1;
    end else if (ph == PH_SKIP) begin
      skip_left--;
      if (skip_left == 16'd0) ph = next_info();
    end else begin
      if (word_idx < 4) word_acc |= 32'(b) << (8 * word_idx);
      word_idx++;
      if (word_idx >= word_bytes(ph)) begin
        v = word_acc;
        word_acc = '0;
        word_idx = 0;
        close_word(v);
      end
    end
    byte_pos++;
    if (eof) begin
      emit_records();
      clear_frame_state();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_record();
    record_t  want;
    out_rec_t got;
    got = m_axis_tdata;
    if (expected_records.size() == 0) begin
      $error("record word with nothing expected: kind %0d, tdata 0x%0h", m_axis_tuser, got);
      n_errors++;
      return;
    end
    want = expected_records.pop_front();
    check_field("record_kind", want.kind, m_axis_tuser);
    check_field("status", want.fields.status, got.status);
    check_field("items_total", want.fields.items_total, got.items_total);
    check_field("type_id", want.fields.type_id, got.type_id);
    check_field("item_length", want.fields.item_length, got.item_length);
    check_field("connection_id", want.fields.connection_id, got.connection_id);
    check_field("seq_value", want.fields.seq_value, got.seq_value);
    check_field("payload_offset", want.fields.payload_offset, got.payload_offset);
    check_field("socket_family", want.fields.socket_family, got.socket_family);
    check_field("socket_port", want.fields.socket_port, got.socket_port);
    check_field("socket_addr", want.fields.socket_addr, got.socket_addr);
    check_field("tdata padding", want.fields.pad, got.pad);
    check_field("last_record", want.last, m_axis_tlast);
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    s_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_record();
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (frame_words.size() == 0 && !have_next && !s_axis_tvalid &&
           expected_records.size() == 0))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Byte driver: hold a word until taken, then wait out the next word's gap
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_taken)) begin
      if (!have_next && frame_words.size() != 0) begin
        next_word = frame_words.pop_front();
        have_next = 1'b1;
      end
      if (have_next && next_word.gap == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_word.data;
        s_axis_tlast  <= next_word.eof;
        have_next = 1'b0;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (have_next) next_word.gap--;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) stall_left = pick_gap(stall_pct);
    m_axis_tready <= (stall_left == 0);
    if (stall_left != 0) stall_left--;
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("cpf_item_parser_core verification failed");
    $finish;
  end

  task automatic put16(input logic [15:0] w);
    frame_buf.push_back(w[7:0]);
    frame_buf.push_back(w[15:8]);
  endtask

  task automatic put32(input logic [31:0] w);
    put16(w[15:0]);
    put16(w[31:16]);
  endtask

  task automatic put_info(input logic [15:0] itype);
    put16(itype);
    put16(($urandom_range(3) == 0) ? 16'($urandom) : 16'd18);
    put16(($urandom_range(1) == 0) ? 16'd2 : 16'($urandom));
    put16(16'($urandom));
    put32($urandom);
    repeat (8) frame_buf.push_back(8'($urandom));
  endtask

  // Queue the buffered frame, cut to its first keep bytes when keep is nonzero
  task automatic send_frame(input int unsigned keep);
    frame_word_t fw;
    int unsigned n;
    n = (keep == 0 || keep >= frame_buf.size()) ? frame_buf.size() : keep;
    for (int unsigned i = 0; i < n; i++) begin
      fw.data = frame_buf[i];
      fw.eof  = (i == n - 1);
      fw.gap  = pick_gap(idle_pct);
      frame_words.push_back(fw);
    end
    frame_buf.delete();
    sent_bytes += n;
    n_frames++;
  endtask

  task automatic random_frame();
    logic [15:0] cnt, alen, dlen, itype;
    int unsigned r, n_info, keep;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(12, 1)) frame_buf.push_back(8'($urandom));
      send_frame(0);
      return;
    end
    r = $urandom_range(99);
    cnt = (r < 8) ? 16'd0 : (r < 18) ? 16'd1 : (r < 40) ? 16'd2 : (r < 65) ? 16'd3 :
          (r < 85) ? 16'd4 : 16'($urandom);
    put16(cnt);
    if (cnt >= 16'd1) begin
      r = $urandom_range(99);
      alen = (r < 15) ? 16'($urandom_range(3)) : (r < 50) ? 16'd4 : (r < 85) ? 16'd8 :
             16'($urandom);
      put16(16'($urandom));
      put16(alen);
      if (alen >= 16'd4) put32($urandom);
      if (alen == 16'd8) put32($urandom);
    end
    if (cnt >= 16'd2) begin
      dlen = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 9)) : 16'($urandom_range(6));
      put16(16'($urandom));
      put16(dlen);
      repeat (dlen) frame_buf.push_back(8'($urandom));
    end
    if (cnt > 16'd2) begin
      n_info = (32'(cnt) - 2 < INFO_ITEMS_DEF) ? 32'(cnt) - 2 : INFO_ITEMS_DEF;
      for (int unsigned i = 0; i < n_info; i++) begin
        r = $urandom_range(99);
        itype = (r < 45) ? o2t_type : (r < 90) ? t2o_type : 16'($urandom);
        if (itype != o2t_type && itype != t2o_type) begin
          put16(itype);
          break;
        end
        put_info(itype);
      end
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(4, 1)) frame_buf.push_back(8'($urandom));
    keep = ($urandom_range(6) == 0 && frame_buf.size() > 1) ?
           $urandom_range(frame_buf.size() - 1, 1) : 0;
    send_frame(keep);
  endtask

  // Hold the sender until every queued byte is taken and every record is back
  task automatic drain();
    while (frame_words.size() != 0 || have_next || s_axis_tvalid ||
           expected_records.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned s_pct, input int unsigned m_pct);
    idle_pct   = s_pct;
    stall_pct  = m_pct;
    sent_bytes = 0;
    n_frames   = 0;
    while (sent_bytes < 70 || n_frames < 3) random_frame();
    drain();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_IDX_O2T) o2t_type = val;
    else if (idx == CFG_IDX_T2O) t2o_type = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] same_type;
    clear_frame_state();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // empty item list, count cut short, bare address item, trailing byte after data item
    put16(16'h0000);
    send_frame(0);
    frame_buf.push_back(8'hFF);
    send_frame(0);
    put16(16'd1);
    put16(16'hFFFF);
    put16(16'd0);
    send_frame(0);
    put16(16'd2);
    put16(16'h00A1);
    put16(16'd4);
    put32(32'hFFFF_FFFF);
    put16(16'h00B1);
    put16(16'd0);
    frame_buf.push_back(8'h00);
    send_frame(0);
    drain();

    run_random(0, 0);

    write_reg(CFG_IDX_O2T, 16'h0000);
    write_reg(CFG_IDX_T2O, 16'hFFFF);
    write_reg(8'hFF, 16'hFFFF);
    run_random(30, 30);

    same_type = 16'($urandom);
    write_reg(CFG_IDX_O2T, same_type);
    write_reg(CFG_IDX_T2O, same_type);
    run_random(60, 10);

    write_reg(CFG_IDX_O2T, 16'($urandom));
    write_reg(CFG_IDX_T2O, 16'($urandom));
    write_reg(8'($urandom_range(254, 2)), 16'($urandom));
    run_random(15, 60);

    write_reg(CFG_IDX_O2T, O2T_TYPE_RESET);
    write_reg(CFG_IDX_T2O, T2O_TYPE_RESET);
    run_random(20, 20);

    if (expected_records.size() != 0) begin
      $error("%0d records never arrived", expected_records.size());
      n_errors++;
    end
    if (n_errors == 0)
      $display("cpf_item_parser_core verification clean");
    else
      $display("cpf_item_parser_core verification failed");
    $finish;
  end

endmodule
